>>> hw/rtl/pdgm_pkg.sv
// ----------------------------------------------------------------------------
// pdgm_pkg
// Shared types, constants and saturation helpers for the PCM decode, gain,
// pan and mix block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdgm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] PAN_COEF_RESET = 16'd23170;

  localparam int unsigned ACC_W  = 40;
  localparam int unsigned SUM_W  = ACC_W + 1;
  localparam int unsigned MG_W   = 48;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned RND_SH = 27;

  typedef enum logic [1:0] {
    FMT_PCM16   = 2'd0,
    FMT_PCM24   = 2'd1,
    FMT_PCM32   = 2'd2,
    FMT_FLOAT32 = 2'd3
  } fmt_e;

  typedef enum logic {
    CFG_PAN_LEFT  = 1'b0,
    CFG_PAN_RIGHT = 1'b1
  } cfg_idx_e;

  // decoded track sample in sign/magnitude form
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    logic [15:0] gain;
    logic        last;
  } item_t;

  function automatic logic [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic [ACC_W-1:0] r;
    if (v[SUM_W-1] != v[SUM_W-2]) begin
      r = v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_q31(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31])) begin
      r = v[31:0];
    end else begin
      r = v[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pdgm_fifo.sv
// ----------------------------------------------------------------------------
// pdgm_fifo
// Short item queue between the decode front and the mix back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdgm_fifo
  import pdgm_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t item_i,
  output logic  full_o,
  input  wire   pop_i,
  output item_t item_o,
  output logic  vld_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o = (cnt_q == CntW'(Depth));
  assign vld_o  = (cnt_q != '0);
  assign item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? nxt(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? nxt(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pdgm_front.sv
// ----------------------------------------------------------------------------
// pdgm_front
// Input side: accepts items and decodes PCM16/24/32 and float32 samples to
// Q1.31 sign/magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module pdgm_front
  import pdgm_pkg::*;
(
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  sample_format_i,
  input  wire  [31:0] raw_sample_i,
  input  wire  [15:0] track_gain_i,
  input  wire         last_track_i,
  input  wire         full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic        neg;
  logic [31:0] mag;
  logic [31:0] pcm;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [23:0] man1;
  logic [7:0]  lsh;
  logic [7:0]  rsh;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    ex   = raw_sample_i[30:23];
    man  = raw_sample_i[22:0];
    man1 = {1'b1, man};
    lsh  = ex - 8'd119;
    rsh  = 8'd119 - ex;
    pcm  = raw_sample_i;
    neg  = 1'b0;
    mag  = '0;
    unique case (fmt_e'(sample_format_i))
      FMT_PCM16: pcm = {raw_sample_i[15:0], 16'h0000};
      FMT_PCM24: pcm = {raw_sample_i[23:0], 8'h00};
      FMT_PCM32: pcm = raw_sample_i;
      FMT_FLOAT32: pcm = raw_sample_i;
      default: pcm = raw_sample_i;
    endcase
    if (fmt_e'(sample_format_i) == FMT_FLOAT32) begin
      neg = raw_sample_i[31];
      if (ex == 8'hFF) begin
        if (man != '0) begin
          neg = 1'b0;
          mag = '0;
        end else begin
          mag = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end else if (ex == 8'h00) begin
        mag = '0;
      end else if (ex >= 8'd127) begin
        mag = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (ex >= 8'd119) begin
        mag = {8'h00, man1} << lsh[2:0];
      end else if (ex >= 8'd95) begin
        mag = {8'h00, man1 >> rsh[4:0]};
      end else begin
        mag = '0;
      end
    end else begin
      neg = pcm[31];
      mag = pcm[31] ? (~pcm + 32'd1) : pcm;
    end
  end

  always_comb begin
    item_o.neg  = neg;
    item_o.mag  = mag;
    item_o.gain = track_gain_i;
    item_o.last = last_track_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/pdgm_back.sv
// ----------------------------------------------------------------------------
// pdgm_back
// Mix side: gain multiply, shared pan multiply for left then right, rounding,
// saturating accumulate and frame output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdgm_back
  import pdgm_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_vld_i,
  input  item_t       q_item_i,
  output logic        pop_o,
  input  wire  [15:0] coef_l_i,
  input  wire  [15:0] coef_r_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] mix_left_o,
  output logic [31:0] mix_right_o
);

  // gain stage
  logic             m_vld_q, m_vld_d;
  logic             m_half_q, m_half_d;
  logic             m_neg_q, m_neg_d;
  logic             m_last_q, m_last_d;
  logic [MG_W-1:0]  mg_q, mg_d;
  // pan product stage
  logic              p_vld_q, p_vld_d;
  logic              p_right_q, p_right_d;
  logic              p_neg_q, p_neg_d;
  logic              p_last_q, p_last_d;
  logic [PROD_W-1:0] p_q, p_d;
  // accumulators and output
  logic [ACC_W-1:0]  acc_l_q, acc_l_d;
  logic [ACC_W-1:0]  acc_r_q, acc_r_d;
  logic              out_vld_q, out_vld_d;
  logic [31:0]       mix_l_q, mix_l_d;
  logic [31:0]       mix_r_q, mix_r_d;

  logic                     en;
  logic                     emit;
  logic [PROD_W-1:0]        p_rnd;
  logic [PROD_W-RND_SH-1:0] r;
  logic signed [PROD_W-RND_SH:0] c;
  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [SUM_W-1:0]  sum;
  logic [15:0]              coef;

  assign emit  = p_vld_q && p_right_q && p_last_q;
  assign en    = !(emit && out_vld_q && out_stall_i);
  assign pop_o = en && q_vld_i && (!m_vld_q || m_half_q);

  assign out_valid_o = out_vld_q;
  assign mix_left_o  = mix_l_q;
  assign mix_right_o = mix_r_q;

  always_comb begin
    coef    = m_half_q ? coef_r_i : coef_l_i;
    p_rnd   = p_q + (PROD_W'(1) << (RND_SH - 1));
    r       = p_rnd[PROD_W-1:RND_SH];
    c       = p_neg_q ? -$signed({1'b0, r}) : $signed({1'b0, r});
    acc_sel = p_right_q ? $signed(acc_r_q) : $signed(acc_l_q);
    sum     = SUM_W'(acc_sel) + SUM_W'(c);
  end

  always_comb begin
    m_vld_d   = m_vld_q;
    m_half_d  = m_half_q;
    m_neg_d   = m_neg_q;
    m_last_d  = m_last_q;
    mg_d      = mg_q;
    p_vld_d   = p_vld_q;
    p_right_d = p_right_q;
    p_neg_d   = p_neg_q;
    p_last_d  = p_last_q;
    p_d       = p_q;
    acc_l_d   = acc_l_q;
    acc_r_d   = acc_r_q;
    mix_l_d   = mix_l_q;
    mix_r_d   = mix_r_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (en) begin
      p_vld_d   = m_vld_q;
      p_right_d = m_half_q;
      p_neg_d   = m_neg_q;
      p_last_d  = m_last_q;
      p_d       = {16'h0000, mg_q} * {48'h0, coef};
      if (m_vld_q && !m_half_q) begin
        m_half_d = 1'b1;
      end else begin
        m_vld_d  = q_vld_i;
        m_half_d = 1'b0;
        m_neg_d  = q_item_i.neg;
        m_last_d = q_item_i.last;
        mg_d     = {16'h0000, q_item_i.mag} * {32'h0, q_item_i.gain};
      end
      if (p_vld_q) begin
        if (p_right_q) begin
          acc_r_d = sat_acc(sum);
        end else begin
          acc_l_d = sat_acc(sum);
        end
      end
      if (emit) begin
        out_vld_d = 1'b1;
        mix_l_d   = sat_q31(SUM_W'($signed(acc_l_q)));
        mix_r_d   = sat_q31(sum);
        acc_l_d   = '0;
        acc_r_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      m_half_q  <= 1'b0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      acc_l_q   <= '0;
      acc_r_q   <= '0;
    end else begin
      m_vld_q   <= m_vld_d;
      m_half_q  <= m_half_d;
      p_vld_q   <= p_vld_d;
      out_vld_q <= out_vld_d;
      acc_l_q   <= acc_l_d;
      acc_r_q   <= acc_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_neg_q   <= m_neg_d;
    m_last_q  <= m_last_d;
    mg_q      <= mg_d;
    p_right_q <= p_right_d;
    p_neg_q   <= p_neg_d;
    p_last_q  <= p_last_d;
    p_q       <= p_d;
    mix_l_q   <= mix_l_d;
    mix_r_q   <= mix_r_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/pcm_decode_gain_pan_mixer.sv
// ----------------------------------------------------------------------------
// pcm_decode_gain_pan_mixer
// Multitrack mixer: decodes one track sample per item, applies track gain and
// equal-power pan, and emits a saturated stereo mix on the last track.
//
//   channel   direction   handshake                      payload
//   in        sink        in_valid_i / in_stall_o        format, raw, gain, last
//   out       source      out_valid_o / out_stall_i      mix_left, mix_right
//   cfg       sink        cfg_we_i (no wait)             cfg_idx_i, cfg_wdata_i
//
// Items pass the gain, pan product and accumulator/output registers; the
// shared pan multiplier makes the left, then the right product, so the next
// item is popped only once the current one is on its right product. Reset
// sets both pan coefficients to 23170 and clears the accumulators. A waiting
// result only holds the back end when another frame ends; the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_decode_gain_pan_mixer
  import pdgm_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  sample_format_i,
  input  wire  [31:0] raw_sample_i,
  input  wire  [15:0] track_gain_i,
  input  wire         last_track_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic signed [31:0] mix_left_o,
  output logic signed [31:0] mix_right_o,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i
);

  logic [15:0] coef_l_q;
  logic [15:0] coef_r_q;
  logic        push;
  logic        full;
  logic        pop;
  logic        q_vld;
  item_t       fr_item;
  item_t       q_item;
  logic [31:0] mix_l;
  logic [31:0] mix_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_l_q <= PAN_COEF_RESET;
      coef_r_q <= PAN_COEF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PAN_LEFT:  coef_l_q <= cfg_wdata_i;
        CFG_PAN_RIGHT: coef_r_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pdgm_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_format_i (sample_format_i),
    .raw_sample_i    (raw_sample_i),
    .track_gain_i    (track_gain_i),
    .last_track_i    (last_track_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (fr_item)
  );

  pdgm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fr_item),
    .full_o (full),
    .pop_i  (pop),
    .item_o (q_item),
    .vld_o  (q_vld)
  );

  pdgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .coef_l_i    (coef_l_q),
    .coef_r_i    (coef_r_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mix_left_o  (mix_l),
    .mix_right_o (mix_r)
  );

  assign mix_left_o  = $signed(mix_l);
  assign mix_right_o = $signed(mix_r);

endmodule

`default_nettype wire
